>>> rtl/core/rcm_pkg.sv
// Shared types and constants of the RMS current meter.
package rcm_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH     = 2'd0,
        CFG_CALIBRATION_GAIN  = 2'd1,
        CFG_SUPPLY_MILLIVOLTS = 2'd2
    } t_cfg_index;

    localparam int WINDOW_REG_W = 16;
    localparam int GAIN_W       = 32;
    localparam int SUPPLY_W     = 13;

    localparam logic [WINDOW_REG_W-1:0] WINDOW_RESET = 16'd1480;
    localparam logic [GAIN_W-1:0]       GAIN_RESET   = 32'd7281050;
    localparam logic [SUPPLY_W-1:0]     SUPPLY_RESET = 13'd3300;

    // Datapath widths
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int RATIO_W  = GAIN_W + SUPPLY_W;
    localparam int ACC_W    = RATIO_W + ROOT_W;
    localparam int MUL_W    = 32;
    localparam int CS_W     = 34;
    localparam int STEP_W   = 6;
    localparam int RESULT_W = 32;

    localparam int SCALE_DIVISOR = 1000;
    // Scaled value at or above this gives a quotient that no longer fits the result
    localparam logic [ACC_W-1:0] SAT_LIMIT = ACC_W'(SCALE_DIVISOR) << RESULT_W;

    // Division by 1000: q ~ ((x >> 10) * floor(2^41 / 1000)) >> 31, low by at most 4
    localparam int               SCALE_PRE_SHIFT  = 10;
    localparam int               SCALE_POST_SHIFT = 31;
    localparam logic [MUL_W-1:0] SCALE_RECIP      = 32'd2199023255;

    typedef enum logic [15:0] {
        ST_IDLE      = 16'b0000000000000001,
        ST_FILT      = 16'b0000000000000010,
        ST_MAG       = 16'b0000000000000100,
        ST_SQ        = 16'b0000000000001000,
        ST_ACC       = 16'b0000000000010000,
        ST_DIV_MEAN  = 16'b0000000000100000,
        ST_SQRT      = 16'b0000000001000000,
        ST_RATIO     = 16'b0000000010000000,
        ST_PLO       = 16'b0000000100000000,
        ST_PHI       = 16'b0000001000000000,
        ST_ACC_HI    = 16'b0000010000000000,
        ST_SCALE     = 16'b0000100000000000,
        ST_RECIP     = 16'b0001000000000000,
        ST_BACK      = 16'b0010000000000000,
        ST_FIX       = 16'b0100000000000000,
        ST_EMIT      = 16'b1000000000000000
    } t_state;

endpackage

>>> rtl/core/rcm_if.sv
// Valid/ready channel interfaces for samples and RMS results.
interface rcm_sample_if #(
    parameter int SAMPLE_BITS = 12
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rcm_result_if
    import rcm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] rms_current;

    modport source (output valid, output rms_current, input ready);
    modport sink   (input valid, input rms_current, output ready);
endinterface

>>> rtl/core/rms_current_meter.sv
// True-RMS current meter: DC offset tracking, sum of squares, divide, root and scaling.
//
// Samples arrive on i_smp (valid/ready); one RMS result per window leaves on o_res as
// unsigned Q16.16 amps, saturated at all ones. Window length, calibration gain and
// supply voltage are written through the i_cfg_* port; the user must do so only while the
// block is idle, which the block itself does not enforce. A sample is handled in steps:
// transfer, offset update, magnitude, square, accumulate. i_smp.ready is high only in
// the idle state, so a new sample is taken only once the previous one is done. The
// sample that closes a window adds a finishing sequence on one shared compare/subtract
// unit and one 32x32 multiplier: mean division, square root and scaling products. The
// division by 1000 is a reciprocal product, a back-multiply and compare/subtract
// corrections, skipped on saturation. The result is then loaded into the output register
// once that register is free. The result register parts the two sides: a pending result
// does not block new samples, but a next result waits for it to be taken, and no new
// sample is taken meanwhile. Reset (synchronous, active low) restores the default
// configuration, sets the offset to mid-scale and clears the sum, the count and the
// output valid.
module rms_current_meter
    import rcm_pkg::*;
#(
    parameter int SAMPLE_BITS  = 12,
    parameter int FILTER_SHIFT = 10,
    parameter int WINDOW_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rcm_sample_if.sink            i_smp,
    rcm_result_if.source          o_res
);

    localparam int OFF_W = SAMPLE_BITS + FILTER_SHIFT;
    localparam int DIV_W = (WINDOW_BITS + 1 > 10) ? WINDOW_BITS + 1 : 10;
    localparam int K     = SAMPLE_BITS + FILTER_SHIFT;
    localparam logic [OFF_W-1:0] OFF_RESET = OFF_W'(1) << (OFF_W - 1);
    localparam logic [OFF_W:0]   ROUND_UP  = (OFF_W + 1)'((1 << FILTER_SHIFT) - 1);

    t_state                  r_state, n_state;
    logic [WINDOW_REG_W-1:0] r_window;
    logic [GAIN_W-1:0]       r_gain;
    logic [SUPPLY_W-1:0]     r_supply;
    logic [OFF_W-1:0]        r_off, n_off;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [WINDOW_BITS-1:0]  r_seen, n_seen;
    logic [OFF_W-1:0]        r_sfx, n_sfx;
    logic [OFF_W-1:0]        r_mag, n_mag;
    logic [SUM_W-1:0]        r_prod, n_prod;
    logic [SUM_W-1:0]        r_quo, n_quo;
    logic [CS_W-1:0]         r_rem, n_rem;
    logic [DIV_W-1:0]        r_div, n_div;
    logic [ROOT_W-1:0]       r_root, n_root;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [RATIO_W-1:0]      r_ratio, n_ratio;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic [RESULT_W-1:0]     r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    logic [RESULT_W-1:0]     r_out_data, n_out_data;

    // Offset filter terms
    logic             filt_ge;
    logic [OFF_W-1:0] filt_up;
    logic [OFF_W:0]   filt_dn_sum;
    logic [OFF_W-1:0] filt_dn;
    logic [OFF_W-1:0] mag;

    // Accumulate and window terms
    logic [SUM_W:0]                  sum_wide;
    logic [SUM_W-1:0]                sum_sat;
    logic [WINDOW_BITS-1:0]          count;
    logic [WINDOW_BITS+WINDOW_REG_W-1:0] win_wide;
    logic [WINDOW_BITS-1:0]          win_raw;
    logic [WINDOW_BITS-1:0]          win;
    logic                            win_end;

    // Shared units
    logic [CS_W-1:0]  cs_a, cs_b, cs_diff;
    logic [CS_W:0]    cs_full;
    logic             cs_ge;
    logic [MUL_W-1:0] mul_a, mul_b;
    logic [SUM_W-1:0] mul_out;
    logic [ACC_W-1:0] scaled;

    assign filt_ge     = (r_sfx >= r_off);
    assign filt_up     = (r_sfx - r_off) >> FILTER_SHIFT;
    assign filt_dn_sum = {1'b0, r_off - r_sfx} + ROUND_UP;
    assign filt_dn     = OFF_W'(filt_dn_sum >> FILTER_SHIFT);
    assign mag         = (r_sfx >= r_off) ? r_sfx - r_off : r_off - r_sfx;

    assign sum_wide = {1'b0, r_sum} + {1'b0, r_prod};
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign count    = r_seen + WINDOW_BITS'(1);
    assign win_wide = {{WINDOW_BITS{1'b0}}, r_window};
    assign win_raw  = win_wide[WINDOW_BITS-1:0];
    assign win      = (win_raw == '0) ? WINDOW_BITS'(1) : win_raw;
    assign win_end  = (count == '0) || (count >= win);

    assign cs_full = {1'b0, cs_a} - {1'b0, cs_b};
    assign cs_ge   = ~cs_full[CS_W];
    assign cs_diff = cs_full[CS_W-1:0];
    assign mul_out = SUM_W'(mul_a) * SUM_W'(mul_b);
    assign scaled  = r_acc >> K;

    // Operand selection for the shared compare/subtract unit and multiplier
    always_comb begin
        cs_a  = '0;
        cs_b  = '0;
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DIV_MEAN: begin
                cs_a = {r_rem[CS_W-2:0], r_quo[SUM_W-1]};
                cs_b = CS_W'(r_div);
            end
            ST_SQRT: begin
                cs_a = {r_rem[CS_W-3:0], r_quo[SUM_W-1:SUM_W-2]};
                cs_b = CS_W'({r_root, 2'b01});
            end
            ST_SQ: begin
                mul_a = MUL_W'(r_mag);
                mul_b = MUL_W'(r_mag);
            end
            ST_RATIO: begin
                mul_a = r_gain;
                mul_b = MUL_W'(r_supply);
            end
            ST_PLO: begin
                mul_a = r_ratio[MUL_W-1:0];
                mul_b = r_root;
            end
            ST_PHI: begin
                mul_a = MUL_W'(r_ratio[RATIO_W-1:MUL_W]);
                mul_b = r_root;
            end
            ST_RECIP: begin
                mul_a = r_quo[SCALE_PRE_SHIFT+MUL_W-1:SCALE_PRE_SHIFT];
                mul_b = SCALE_RECIP;
            end
            ST_BACK: begin
                // remainder is below 5000, so the low bits of the difference are exact
                mul_a = r_res;
                mul_b = MUL_W'(SCALE_DIVISOR);
                cs_a  = r_quo[CS_W-1:0];
                cs_b  = mul_out[CS_W-1:0];
            end
            ST_FIX: begin
                cs_a = r_rem;
                cs_b = CS_W'(SCALE_DIVISOR);
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_off       = r_off;
        n_sum       = r_sum;
        n_seen      = r_seen;
        n_sfx       = r_sfx;
        n_mag       = r_mag;
        n_prod      = r_prod;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_root      = r_root;
        n_step      = r_step;
        n_ratio     = r_ratio;
        n_acc       = r_acc;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_data  = r_out_data;
        case (r_state)
            ST_IDLE: begin
                if (i_smp.valid) begin
                    n_sfx   = {i_smp.sample[SAMPLE_BITS-1:0], {FILTER_SHIFT{1'b0}}};
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                n_off   = filt_ge ? r_off + filt_up : r_off - filt_dn;
                n_state = ST_MAG;
            end
            ST_MAG: begin
                n_mag   = mag;
                n_state = ST_SQ;
            end
            ST_SQ: begin
                n_prod  = mul_out;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (win_end) begin
                    n_quo   = sum_sat;
                    n_sum   = '0;
                    n_seen  = '0;
                    // a wrapped count means a full 2^WINDOW_BITS window
                    n_div   = (count == '0) ? (DIV_W'(1) << WINDOW_BITS) : DIV_W'(count);
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = ST_DIV_MEAN;
                end else begin
                    n_sum   = sum_sat;
                    n_seen  = count;
                    n_state = ST_IDLE;
                end
            end
            ST_DIV_MEAN: begin
                n_rem  = cs_ge ? cs_diff : cs_a;
                n_quo  = {r_quo[SUM_W-2:0], cs_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_step  = '0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                n_rem  = cs_ge ? cs_diff : cs_a;
                n_root = {r_root[ROOT_W-2:0], cs_ge};
                n_quo  = {r_quo[SUM_W-3:0], 2'b00};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    n_state = ST_RATIO;
                end
            end
            ST_RATIO: begin
                n_ratio = mul_out[RATIO_W-1:0];
                n_state = ST_PLO;
            end
            ST_PLO: begin
                n_prod  = mul_out;
                n_state = ST_PHI;
            end
            ST_PHI: begin
                n_acc   = ACC_W'(r_prod);
                n_prod  = mul_out;
                n_state = ST_ACC_HI;
            end
            ST_ACC_HI: begin
                n_acc   = r_acc + (ACC_W'(r_prod) << MUL_W);
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (scaled >= SAT_LIMIT) begin
                    n_res   = {RESULT_W{1'b1}};
                    n_state = ST_EMIT;
                end else begin
                    n_quo   = scaled[SUM_W-1:0];
                    n_state = ST_RECIP;
                end
            end
            ST_RECIP: begin
                n_res   = mul_out[SCALE_POST_SHIFT+RESULT_W-1:SCALE_POST_SHIFT];
                n_state = ST_BACK;
            end
            ST_BACK: begin
                n_rem   = cs_diff;
                n_state = ST_FIX;
            end
            ST_FIX: begin
                // estimate is never high; bump it until the remainder is below 1000
                if (cs_ge) begin
                    n_rem = cs_diff;
                    n_res = r_res + RESULT_W'(1);
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_off       <= OFF_RESET;
            r_sum       <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_off       <= n_off;
            r_sum       <= n_sum;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sfx      <= n_sfx;
        r_mag      <= n_mag;
        r_prod     <= n_prod;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_root     <= n_root;
        r_step     <= n_step;
        r_ratio    <= n_ratio;
        r_acc      <= n_acc;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_gain   <= GAIN_RESET;
            r_supply <= SUPPLY_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH:     r_window <= i_cfg_wdata[WINDOW_REG_W-1:0];
                CFG_CALIBRATION_GAIN:  r_gain   <= i_cfg_wdata[GAIN_W-1:0];
                CFG_SUPPLY_MILLIVOLTS: r_supply <= i_cfg_wdata[SUPPLY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_smp.ready       = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.rms_current = r_out_data;

endmodule

>>> tb/rcm_rms_checker.sv
`timescale 1ns / 1ps
// Checker for the RMS current meter: tracks samples, predicts RMS results, compares them.
module rcm_rms_checker
    import rcm_pkg::*;
#(
    parameter int SAMPLE_BITS  = 12,
    parameter int FILTER_SHIFT = 10,
    parameter int WINDOW_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rcm_sample_if                 i_smp,
    rcm_result_if                 i_res,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_results
);

    localparam int OFS_W = SAMPLE_BITS + FILTER_SHIFT;
    localparam logic [OFS_W-1:0] OFS_MID = OFS_W'(1) << (SAMPLE_BITS - 1 + FILTER_SHIFT);
    localparam logic [31:0] WIN_MASK = (32'd1 << WINDOW_BITS) - 32'd1;

    // predictor state and its copy of the registers
    logic [OFS_W-1:0]        ofs_est;
    logic [SUM_W-1:0]        sq_sum;
    logic [WINDOW_BITS-1:0]  seen;
    logic [WINDOW_REG_W-1:0] win_len;
    logic [GAIN_W-1:0]       gain;
    logic [SUPPLY_W-1:0]     supply;

    logic [RESULT_W-1:0] rms_expected[$];

    function automatic logic [31:0] isqrt_floor(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic [RESULT_W-1:0] rms_of_window(input logic [31:0] count);
        logic [127:0] amps;
        amps = 128'(gain) * 128'(supply) * 128'(isqrt_floor(sq_sum / 64'(count)));
        amps = (amps >> (SAMPLE_BITS + FILTER_SHIFT)) / 128'(SCALE_DIVISOR);
        return (amps > 128'hFFFF_FFFF) ? '1 : amps[RESULT_W-1:0];
    endfunction

    function automatic void take_sample(input logic [SAMPLE_BITS-1:0] s);
        logic [OFS_W-1:0]        s_fx;
        logic [OFS_W-1:0]        mag;
        logic signed [OFS_W+1:0] dlt;
        logic [SUM_W:0]          grown;
        logic [31:0]             cnt;
        logic [31:0]             lim;
        s_fx = OFS_W'(s) << FILTER_SHIFT;
        // arithmetic shift gives the floor of the signed step
        dlt = $signed({2'b00, s_fx}) - $signed({2'b00, ofs_est});
        ofs_est = OFS_W'($signed({2'b00, ofs_est}) + (dlt >>> FILTER_SHIFT));
        mag = (s_fx >= ofs_est) ? s_fx - ofs_est : ofs_est - s_fx;
        grown = {1'b0, sq_sum} + {1'b0, 64'(mag) * 64'(mag)};
        sq_sum = grown[SUM_W] ? '1 : grown[SUM_W-1:0];
        cnt = 32'(seen) + 32'd1;
        lim = 32'(win_len) & WIN_MASK;
        if (lim == 0) lim = 32'd1;
        // count past the mask means the counter wrapped: full 2^WINDOW_BITS window
        if (cnt > WIN_MASK || cnt >= lim) begin
            rms_expected.push_back(rms_of_window(cnt));
            sq_sum = '0;
            seen   = '0;
        end else begin
            seen = cnt[WINDOW_BITS-1:0];
        end
    endfunction

    always @(posedge i_clk) begin
        logic [RESULT_W-1:0] want;
        if (!i_rst_n) begin
            ofs_est = OFS_MID;
            sq_sum  = '0;
            seen    = '0;
            win_len = WINDOW_RESET;
            gain    = GAIN_RESET;
            supply  = SUPPLY_RESET;
            rms_expected.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_WINDOW_LENGTH:     win_len = i_cfg_wdata[WINDOW_REG_W-1:0];
                    CFG_CALIBRATION_GAIN:  gain    = i_cfg_wdata[GAIN_W-1:0];
                    CFG_SUPPLY_MILLIVOLTS: supply  = i_cfg_wdata[SUPPLY_W-1:0];
                    default: ;
                endcase
            end
            if (i_smp.valid && i_smp.ready) take_sample(i_smp.sample);
            if (i_res.valid && i_res.ready) begin
                o_results++;
                if (rms_expected.size() == 0) begin
                    $error("rms_current: expected no transfer, got %0d", i_res.rms_current);
                    o_fail_count++;
                end else begin
                    want = rms_expected.pop_front();
                    if (i_res.rms_current !== want) begin
                        $error("rms_current: expected %0d, got %0d", want, i_res.rms_current);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = rms_expected.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the RMS current meter: clock, reset, stimulus and verdict.
module tb_top;
    import rcm_pkg::*;

    localparam int SAMPLE_BITS  = 12;
    localparam int FILTER_SHIFT = 10;
    localparam int WINDOW_BITS  = 16;

    localparam int RESET_CYCLES        = 11;
    localparam int IDLE_PCT            = 36;
    localparam int HOLD_CYCLES         = 600;
    localparam int SETTLE_CYCLES       = 200;
    localparam int STALL_LIMIT         = 5000;
    localparam int RANDOM_SETTINGS     = 11;
    localparam int SAMPLES_PER_SETTING = 110;
    localparam int STEADY_SETTING      = 4;
    localparam int PRESSURE_SETTING    = 7;
    localparam int SMP_TOP             = (1 << SAMPLE_BITS) - 1;

    localparam logic [CFG_IDX_W-1:0]   CFG_INDEX_SPARE = 2'd3;
    localparam logic [SAMPLE_BITS-1:0] SMP_ALT         = {(SAMPLE_BITS / 2){2'b10}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MID         = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [SUPPLY_W-1:0]    SUPPLY_MAX      = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rcm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp ();
    rcm_result_if res ();

    int fail_count;
    int pending;
    int results_seen;
    int samples_sent;
    int settings_used;
    int stall_cycles;
    bit no_idle;
    bit hold_req;

    logic [WINDOW_REG_W-1:0] win;
    logic [GAIN_W-1:0]       gain;
    logic [SUPPLY_W-1:0]     supply;
    int                      center;
    int                      amp;

    rms_current_meter #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FILTER_SHIFT(FILTER_SHIFT),
        .WINDOW_BITS (WINDOW_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata),
        .i_smp      (smp),
        .o_res      (res)
    );

    rcm_rms_checker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FILTER_SHIFT(FILTER_SHIFT),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_smp       (smp),
        .i_res       (res),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_results   (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: random backpressure, one long hold-off on request
    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper data bits are junk to exercise the register masks
    task automatic configure(input logic [WINDOW_REG_W-1:0] w, input logic [GAIN_W-1:0] g,
                             input logic [SUPPLY_W-1:0] s);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_WINDOW_LENGTH, {junk[31:16], w});
        write_reg(CFG_CALIBRATION_GAIN, g);
        write_reg(CFG_SUPPLY_MILLIVOLTS, {junk[18:0], s});
        write_reg(CFG_INDEX_SPARE, $urandom);
        settings_used++;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid  <= 1'b1;
        smp.sample <= value;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        samples_sent++;
    endtask

    // nothing in flight: all results in, plus room for a non-closing sample to finish
    task automatic wait_idle();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int c, input int a);
        int v;
        if ($urandom_range(99) < 20) return SAMPLE_BITS'($urandom);
        v = c - a + int'($urandom_range(2 * a));
        if (v < 0) v = 0;
        if (v > SMP_TOP) v = SMP_TOP;
        return SAMPLE_BITS'(v);
    endfunction

    initial begin
        i_rst_n    <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= CFG_WINDOW_LENGTH;
        cfg_wdata  <= '0;
        smp.valid  <= 1'b0;
        smp.sample <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers, then the window shrinks below the count already taken
        send_sample('0);
        send_sample('1);
        send_sample(SMP_ALT);
        send_sample(~SMP_ALT);
        send_sample(SMP_MID);
        wait_idle();
        write_reg(CFG_WINDOW_LENGTH, 32'd1);
        send_sample('0);
        wait_idle();

        // zero window, largest gain and supply: saturated results
        configure('0, '1, SUPPLY_MAX);
        send_sample('0);
        send_sample('1);
        send_sample('0);
        send_sample('1);
        wait_idle();

        configure(16'd2, '0, '0);
        send_sample('1);
        send_sample('0);
        wait_idle();

        configure(16'd3, 32'h0001_0000, 13'd5000);
        send_sample(SAMPLE_BITS'(1));
        send_sample(SAMPLE_BITS'(SMP_TOP - 1));
        send_sample(SMP_MID - 1'b1);
        wait_idle();

        // longest window, closed early by a shrink
        configure('1, GAIN_RESET, SUPPLY_RESET);
        repeat (5) send_sample(pick_sample(SMP_MID, SMP_MID));
        wait_idle();
        write_reg(CFG_WINDOW_LENGTH, 32'd4);
        send_sample(SMP_MID);
        wait_idle();

        for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
            case ($urandom_range(9))
                0:       win = '0;
                1:       win = WINDOW_REG_W'($urandom_range(64, 1));
                default: win = WINDOW_REG_W'($urandom_range(8, 1));
            endcase
            case ($urandom_range(5))
                0:       gain = '1;
                1:       gain = '0;
                2:       gain = $urandom;
                default: gain = $urandom_range(32'h0100_0000);
            endcase
            case ($urandom_range(5))
                0:       supply = SUPPLY_MAX;
                1:       supply = '0;
                default: supply = SUPPLY_W'($urandom_range(5000));
            endcase
            if (ph == PRESSURE_SETTING) win = 16'd1;
            configure(win, gain, supply);
            no_idle = (ph == STEADY_SETTING);
            if (ph == PRESSURE_SETTING) hold_req = 1'b1;
            center = $urandom_range(3072, 1024);
            amp    = $urandom_range(SMP_MID - 1);
            repeat (SAMPLES_PER_SETTING) send_sample(pick_sample(center, amp));
            no_idle = 1'b0;
            wait_idle();
        end

        $display("tb_top: %0d samples under %0d register settings, %0d RMS results compared",
                 samples_sent, settings_used, results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rcm_pkg.sv
rtl/core/rcm_if.sv
rtl/core/rms_current_meter.sv
tb/rcm_rms_checker.sv
tb/tb_top.sv
